// File: hdl/cda_pkg.sv
// Types, codes and constants shared by the calendar date adder.
package cda_pkg;

  localparam logic [13:0] MAX_YEAR    = 14'd9999;
  localparam logic [13:0] RESET_YEAR  = 14'd2000;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam int unsigned YEAR_WORK_W = 17;

  // floor(x / 100) and floor(x / 12) as (x * K) >> RECIP_SHIFT
  localparam logic [15:0] RECIP_100   = 16'd5243;
  localparam logic [15:0] RECIP_12    = 16'd43691;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DAYS   = 2'd1,
    ACT_MONTHS = 2'd2,
    ACT_YEARS  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_MUL,
    S_LEAP_CHK,
    S_DAYS,
    S_MON_MUL,
    S_MON_FIX,
    S_CHECK,
    S_CLAMP,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic        error;
  } out_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/calendar_date_adder.sv
// Gregorian calendar date register with load, add days, add months and add years.
// One transaction at a time: the input stalls from acceptance until the result has
// been moved into the output register. Add days walks one month per cycle through
// the day loop, except that each year crossed goes back through S_LEAP_MUL and
// S_LEAP_CHK on the shared multiplier that derives the leap-year flag. The result
// waits in S_DONE while the output register is still held by a stalled earlier
// result.
module calendar_date_adder
  import cda_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
  localparam int unsigned YW = YEAR_WORK_W;

  state_e state_q, state_d;
  in_t    in_q, in_d;

  logic [YW-1:0] wy_q, wy_d;
  logic [3:0]    wm_q, wm_d;
  logic [4:0]    wd_q, wd_d;
  logic [AW-1:0] left_q, left_d;
  logic          err_q, err_d;
  logic          leap_q, leap_d;
  logic [31:0]   prod_q, prod_d;

  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic        commit;

  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        out_free;
  logic        out_load;

  logic [AW-1:0] amt_in;
  logic [AW-1:0] amt;
  logic [YW-1:0] yadd;
  logic [YW-1:0] mon_total;
  logic [YW-1:0] mul_a;
  logic [15:0]   mul_k;
  logic [12:0]   quo;
  logic [13:0]   r100;
  logic [YW-1:0] r12;
  logic [YW-1:0] ny;
  logic [4:0]    mlen;
  logic [AW:0]   day_sum;
  logic          day_fits;
  logic [4:0]    day_step;
  logic          load_ok;

  assign amt_in    = in_data_i.amount[AW-1:0];
  assign amt       = in_q.amount[AW-1:0];
  assign yadd      = {3'b000, year_q} + YW'(amt_in);
  assign mon_total = YW'(wm_q - 4'd1) + YW'(amt);

  // shared reciprocal multiplier
  assign mul_a  = (state_q == S_MON_MUL) ? mon_total : {3'b000, wy_q[13:0]};
  assign mul_k  = (state_q == S_MON_MUL) ? RECIP_12 : RECIP_100;
  assign prod_d = 32'(mul_a) * 32'(mul_k);
  assign quo    = prod_q[31:RECIP_SHIFT];

  assign r100   = wy_q[13:0] - 14'({6'b000000, quo[7:0]} * 14'd100);
  assign leap_d = ((wy_q[1:0] == 2'b00) && (r100 != 14'd0)) ||
                  ((r100 == 14'd0) && (quo[1:0] == 2'b00));

  assign r12 = mon_total - YW'({4'b0000, quo} * YW'(12));
  assign ny  = wy_q + YW'(quo);

  assign mlen     = month_days(wm_q, leap_q);
  assign day_sum  = {{(AW + 1 - 5){1'b0}}, wd_q} + {1'b0, left_q};
  assign day_fits = day_sum <= {{(AW + 1 - 5){1'b0}}, mlen};
  assign day_step = mlen - wd_q + 5'd1;

  assign load_ok = (wy_q <= YW'(MAX_YEAR)) && (wm_q >= 4'd1) && (wm_q <= 4'd12) &&
                   (wd_q >= 5'd1) && (wd_q <= mlen);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_DONE) && out_free;
  assign commit   = out_load && !err_q;

  always_comb begin
    state_d = state_q;
    in_d    = in_q;
    wy_d    = wy_q;
    wm_d    = wm_q;
    wd_d    = wd_q;
    left_d  = left_q;
    err_d   = err_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d   = in_data_i;
          wy_d   = {3'b000, year_q};
          wm_d   = month_q;
          wd_d   = day_q;
          left_d = amt_in;
          err_d  = 1'b0;
          case (in_data_i.action)
            ACT_LOAD: begin
              wy_d    = {3'b000, in_data_i.year_value};
              wm_d    = in_data_i.month_value;
              wd_d    = in_data_i.day_value;
              state_d = S_LEAP_MUL;
            end
            ACT_DAYS:   state_d = S_LEAP_MUL;
            ACT_MONTHS: state_d = S_MON_MUL;
            ACT_YEARS: begin
              wy_d = yadd;
              if (yadd > YW'(MAX_YEAR)) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_LEAP_MUL;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LEAP_MUL: state_d = S_LEAP_CHK;
      S_LEAP_CHK: begin
        case (in_q.action)
          ACT_LOAD: state_d = S_CHECK;
          ACT_DAYS: state_d = S_DAYS;
          default:  state_d = S_CLAMP;
        endcase
      end
      S_DAYS: begin
        if (day_fits) begin
          wd_d    = day_sum[4:0];
          state_d = S_DONE;
        end else begin
          left_d = left_q - {{(AW - 5){1'b0}}, day_step};
          wd_d   = 5'd1;
          if (wm_q == 4'd12) begin
            wm_d = 4'd1;
            if (wy_q >= YW'(MAX_YEAR)) begin
              err_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              wy_d    = wy_q + YW'(1);
              state_d = S_LEAP_MUL;
            end
          end else begin
            wm_d = wm_q + 4'd1;
          end
        end
      end
      S_MON_MUL: state_d = S_MON_FIX;
      S_MON_FIX: begin
        wy_d = ny;
        wm_d = r12[3:0] + 4'd1;
        if (ny > YW'(MAX_YEAR)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_LEAP_MUL;
        end
      end
      S_CHECK: begin
        err_d   = !load_ok;
        state_d = S_DONE;
      end
      S_CLAMP: begin
        if (wd_q > mlen) begin
          wd_d = mlen;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d.error = err_q;
    if (err_q) begin
      out_d.cur_year  = year_q;
      out_d.cur_month = month_q;
      out_d.cur_day   = day_q;
    end else begin
      out_d.cur_year  = wy_q[13:0];
      out_d.cur_month = wm_q;
      out_d.cur_day   = wd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      year_q      <= RESET_YEAR;
      month_q     <= RESET_MONTH;
      day_q       <= RESET_DAY;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        year_q  <= wy_q[13:0];
        month_q <= wm_q;
        day_q   <= wd_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    wy_q   <= wy_d;
    wm_q   <= wm_d;
    wd_q   <= wd_d;
    left_q <= left_d;
    err_q  <= err_d;
    prod_q <= prod_d;
    if (state_q == S_LEAP_CHK) begin
      leap_q <= leap_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_q <= MAX_YEAR) && (month_q >= 4'd1) && (month_q <= 4'd12) && (day_q >= 5'd1))
    else $error("held date out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transaction accepted");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result presented outside completion");

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DAYS) |-> ((wm_q >= 4'd1) && (wm_q <= 4'd12) && (wd_q >= 5'd1)))
    else $error("day walk left the valid month range");
`endif

endmodule
